### hw/rtl/mgis_pkg.sv
// Shared types and constants for the microbial GA tournament step block.
package mgis_pkg;

  localparam int PopSize    = 128;
  localparam int GeneCount  = 32;
  localparam int GeneWidth  = 16;
  localparam int PopW       = 7;
  localparam int GeneIdxW   = 5;
  localparam int AddrW      = PopW + GeneIdxW;
  localparam int TryLimit   = 64;
  localparam int TryW       = 7;
  localparam logic [31:0] LfsrTaps = 32'hD000_0001;

  typedef enum logic [1:0] {
    OP_WR_GENE = 2'd0,
    OP_WR_FIT  = 2'd1,
    OP_TOURN   = 2'd2,
    OP_RD_GENE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EQUAL = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GENE_MIN = 3'd0;
  localparam logic [2:0] REG_GENE_MAX = 3'd1;
  localparam logic [2:0] REG_RECOMB   = 3'd2;
  localparam logic [2:0] REG_MUTATE   = 3'd3;
  localparam logic [2:0] REG_GENES    = 3'd4;
  localparam logic [2:0] REG_POP      = 3'd5;
  localparam logic [2:0] REG_SEED     = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch input item
    logic fit_rd;      // read both fitnesses
    logic decide;      // pick winner and loser
    logic gene_rd;     // read winner and loser gene at gene counter
    logic recomb;      // recombine draw, pick working value
    logic mut_draw;    // mutate decision draw
    logic exp_draw;    // exponent draw
    logic coin_step;   // coin draw and step
    logic clamp_wr;    // clamp and write working value
    logic plain_wr;    // write working value unchanged
    logic next_gene;   // advance gene counter
    logic item_wr;     // single write of gene or fitness
    logic item_rd;     // single gene read
    logic emit;        // present result
  } mgis_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic bad_index;
    logic picks_equal;
    logic genes_done;
    logic mut_hit;      // mutate draw of this cycle is below threshold
    logic do_mutate;    // latched mutate decision for the current gene
    logic range_empty;
    logic in_range;
    logic tries_done;
  } mgis_sts_t;

endpackage

### hw/rtl/microbial_ga_integer_step.sv
// Top level of the microbial GA tournament step block.
//  channel  | ports                                   | handshake
//  input    | in_opcode .. in_fitness_value           | start & !busy
//  result   | out_loser_index .. out_status           | out_valid, one cycle
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready high
// Load and read items pass the check and done states from start to result.
// A tournament passes the check, fitness read and decide states, then per
// gene a read, recombine, mutate draw and write; a gene that mutates adds an
// exponent draw and coin step per mutation attempt (at most 64 attempts).
// Reset (rst_n low, synchronous) returns registers to defaults, LFSR to 1.
// The receiver cannot stall; busy holds off new items until the result.
module microbial_ga_integer_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [6:0]         in_first_pick,
  input  logic [6:0]         in_second_pick,
  input  logic [4:0]         in_gene_index,
  input  logic signed [15:0] in_gene_value,
  input  logic signed [31:0] in_fitness_value,
  output logic               out_valid,
  output logic [6:0]         out_loser_index,
  output logic [6:0]         out_winner_index,
  output logic signed [15:0] out_read_value,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mgis_pkg::*;

  mgis_cmd_t cmd;
  mgis_sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign out_valid = cmd.emit;

  mgis_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .sts, .cmd
  );

  mgis_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_opcode, .in_first_pick, .in_second_pick, .in_gene_index,
    .in_gene_value, .in_fitness_value,
    .cfg_we, .cfg_idx(paddr[4:2]), .cfg_wdata(pwdata), .cfg_rdata(prdata),
    .out_loser_index, .out_winner_index, .out_read_value, .out_status
  );
endmodule

### hw/rtl/mgis_ctrl.sv
// Controller state machine for the microbial GA tournament step block.
module mgis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mgis_pkg::mgis_sts_t sts,
  output mgis_pkg::mgis_cmd_t cmd
);
  import mgis_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_CHECK  = 11'b000_0000_0010,
    S_FIT    = 11'b000_0000_0100,
    S_DECIDE = 11'b000_0000_1000,
    S_GRD    = 11'b000_0001_0000,
    S_RECOMB = 11'b000_0010_0000,
    S_MDRAW  = 11'b000_0100_0000,
    S_EXP    = 11'b000_1000_0000,
    S_COIN   = 11'b001_0000_0000,
    S_WRITE  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_index) state_nxt = S_DONE;
        else begin
          unique case (sts.op)
            OP_TOURN: state_nxt = sts.picks_equal ? S_DONE : S_FIT;
            OP_RD_GENE: begin
              cmd.item_rd = 1'b1;
              state_nxt   = S_DONE;
            end
            default: begin
              cmd.item_wr = 1'b1;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end
      S_FIT: begin
        cmd.fit_rd = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_GRD;
      end
      S_GRD: begin
        if (sts.genes_done) state_nxt = S_DONE;
        else begin
          cmd.gene_rd = 1'b1;
          state_nxt   = S_RECOMB;
        end
      end
      S_RECOMB: begin
        cmd.recomb = 1'b1;
        state_nxt  = S_MDRAW;
      end
      S_MDRAW: begin
        cmd.mut_draw = 1'b1;
        state_nxt    = (sts.mut_hit && !sts.range_empty) ? S_EXP : S_WRITE;
      end
      S_EXP: begin
        cmd.exp_draw = 1'b1;
        state_nxt    = S_COIN;
      end
      S_COIN: begin
        cmd.coin_step = 1'b1;
        state_nxt     = S_WRITE;
      end
      S_WRITE: begin
        // After a step: retry while out of range and attempts remain
        if (sts.do_mutate && !sts.range_empty && !sts.in_range && !sts.tries_done) begin
          state_nxt = S_EXP;
        end else begin
          if (sts.do_mutate && !sts.range_empty) cmd.clamp_wr = 1'b1;
          else                                   cmd.plain_wr = 1'b1;
          cmd.next_gene = 1'b1;
          state_nxt     = S_GRD;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (state_r == S_IDLE))
    else $error("result state not followed by idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (state_r == S_DONE))
    else $error("result emitted outside done state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_CHECK))
    else $error("accepted item did not enter check");
endmodule

### hw/rtl/mgis_datapath.sv
// Datapath: stores, LFSR, configuration registers and mutation arithmetic.
module mgis_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mgis_pkg::mgis_cmd_t cmd,
  output mgis_pkg::mgis_sts_t sts,
  input  logic [1:0]          in_opcode,
  input  logic [6:0]          in_first_pick,
  input  logic [6:0]          in_second_pick,
  input  logic [4:0]          in_gene_index,
  input  logic signed [15:0]  in_gene_value,
  input  logic signed [31:0]  in_fitness_value,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_wdata,
  output logic [31:0]         cfg_rdata,
  output logic [6:0]          out_loser_index,
  output logic [6:0]          out_winner_index,
  output logic signed [15:0]  out_read_value,
  output logic [1:0]          out_status
);
  import mgis_pkg::*;

  // Configuration registers
  logic signed [15:0] gene_min_r, gene_max_r;
  logic [10:0] recomb_th_r, mutate_th_r;
  logic [5:0]  genes_r;
  logic [7:0]  pop_r;
  logic [31:0] seed_r;
  logic [31:0] lfsr_r, lfsr_nxt;

  // Item registers
  op_t        op_r;
  logic [PopW-1:0] a_r, b_r, win_r, lose_r;
  logic [GeneIdxW-1:0] g_r;
  logic signed [15:0] gval_r;
  logic signed [31:0] fval_r;
  logic [5:0] gcnt_r;
  logic [GeneWidth-1:0] rd_win_r, rd_lose_r;
  // 64 steps of up to 2^15 from a 16-bit start stay within 24 bits
  logic signed [23:0] val_r;
  logic do_mut_r;
  logic [4:0] k_r;
  logic [TryW-1:0] tries_r;
  logic [4:0] rpow_r;
  logic signed [31:0] fit_a_r, fit_b_r;
  logic [GeneWidth-1:0] rdv_r;

  // Stores
  logic [GeneWidth-1:0] gene_mem [PopSize*GeneCount];
  logic [31:0] fit_mem [PopSize];

  // LFSR advance
  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LfsrTaps) : (lfsr_r >> 1);
  logic draw;
  assign draw = cmd.recomb | cmd.mut_draw | cmd.exp_draw | cmd.coin_step;

  // Effective sizes
  logic [7:0] pop_eff;
  logic [5:0] genes_eff;
  assign pop_eff   = (pop_r > 8'(PopSize)) ? 8'(PopSize) : pop_r;
  assign genes_eff = (genes_r > 6'(GeneCount)) ? 6'(GeneCount) : genes_r;

  // Range and its power of two
  logic signed [16:0] span;
  logic [4:0] rpow_c;
  assign span = 17'(gene_max_r) - 17'(gene_min_r);
  always_comb begin
    rpow_c = '0;
    for (int i = 15; i >= 0; i--) begin
      if (span > (17'sd1 <<< i)) begin
        if (rpow_c == '0) rpow_c = 5'(i + 1);
      end
    end
  end

  // Configuration writes and LFSR
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gene_min_r  <= 16'sd0;
      gene_max_r  <= 16'sd256;
      recomb_th_r <= 11'd512;
      mutate_th_r <= 11'd102;
      genes_r     <= 6'd32;
      pop_r       <= 8'd128;
      seed_r      <= 32'd1;
      lfsr_r      <= 32'd1;
      rpow_r      <= 5'd8;
    end else begin
      rpow_r <= rpow_c;
      if (draw) lfsr_r <= lfsr_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_GENE_MIN: gene_min_r  <= cfg_wdata[15:0];
          REG_GENE_MAX: gene_max_r  <= cfg_wdata[15:0];
          REG_RECOMB:   recomb_th_r <= cfg_wdata[10:0];
          REG_MUTATE:   mutate_th_r <= cfg_wdata[10:0];
          REG_GENES:    genes_r     <= cfg_wdata[5:0];
          REG_POP:      pop_r       <= cfg_wdata[7:0];
          REG_SEED: begin
            seed_r <= cfg_wdata;
            lfsr_r <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GENE_MIN: cfg_rdata = 32'(gene_min_r);
      REG_GENE_MAX: cfg_rdata = 32'(gene_max_r);
      REG_RECOMB:   cfg_rdata = 32'(recomb_th_r);
      REG_MUTATE:   cfg_rdata = 32'(mutate_th_r);
      REG_GENES:    cfg_rdata = 32'(genes_r);
      REG_POP:      cfg_rdata = 32'(pop_r);
      REG_SEED:     cfg_rdata = seed_r;
      default:      cfg_rdata = '0;
    endcase
  end

  // Item capture and checks
  logic bad_c;
  always_comb begin
    unique case (op_r)
      OP_TOURN:  bad_c = (8'(a_r) >= pop_eff) || (8'(b_r) >= pop_eff);
      OP_WR_FIT: bad_c = (8'(a_r) >= pop_eff);
      default:   bad_c = (8'(a_r) >= pop_eff) || (6'(g_r) >= genes_eff);
    endcase
  end

  // Step arithmetic
  logic [63:0] kprod;
  logic signed [23:0] stepped;
  logic inside_c;
  logic mut_hit;
  assign kprod    = lfsr_nxt * 64'(rpow_r);
  assign stepped  = lfsr_nxt[0] ? (val_r - (24'sd1 <<< k_r)) : (val_r + (24'sd1 <<< k_r));
  assign inside_c = (val_r >= 24'(gene_min_r)) && (val_r < 24'(gene_max_r));
  assign mut_hit  = ({1'b0, lfsr_nxt[9:0]} < mutate_th_r);

  logic signed [23:0] clamped;
  always_comb begin
    clamped = val_r;
    if (val_r < 24'(gene_min_r)) clamped = 24'(gene_min_r);
    if (clamped >= 24'(gene_max_r)) clamped = 24'(gene_max_r) - 24'sd1;
  end

  logic [AddrW-1:0] wa, la;
  assign wa = {win_r,  gcnt_r[GeneIdxW-1:0]};
  assign la = {lose_r, gcnt_r[GeneIdxW-1:0]};

  // Gene memory
  always_ff @(posedge clk) begin
    if (cmd.item_wr && op_r == OP_WR_GENE) gene_mem[{a_r, g_r}] <= gval_r;
    if (cmd.clamp_wr) gene_mem[la] <= clamped[GeneWidth-1:0];
    if (cmd.plain_wr) gene_mem[la] <= val_r[GeneWidth-1:0];
    if (cmd.gene_rd) begin
      rd_win_r  <= gene_mem[wa];
      rd_lose_r <= gene_mem[la];
    end
    if (cmd.item_rd) rdv_r <= gene_mem[{a_r, g_r}];
  end

  // Fitness memory
  always_ff @(posedge clk) begin
    if (cmd.item_wr && op_r == OP_WR_FIT) fit_mem[a_r] <= fval_r;
    if (cmd.fit_rd) begin
      fit_a_r <= fit_mem[a_r];
      fit_b_r <= fit_mem[b_r];
    end
  end

  // Sequenced payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_opcode);
      a_r    <= in_first_pick;
      b_r    <= in_second_pick;
      g_r    <= in_gene_index;
      gval_r <= in_gene_value;
      fval_r <= in_fitness_value;
    end
    if (cmd.capture) begin
      win_r  <= '0;
      lose_r <= '0;
      gcnt_r <= '0;
    end
    if (cmd.decide) begin
      if (fit_a_r < fit_b_r) begin
        win_r <= a_r; lose_r <= b_r;
      end else begin
        win_r <= b_r; lose_r <= a_r;
      end
    end
    if (cmd.recomb) begin
      val_r <= ({1'b0, lfsr_nxt[9:0]} < recomb_th_r) ? 24'(signed'(rd_win_r))
                                                      : 24'(signed'(rd_lose_r));
    end
    if (cmd.mut_draw) begin
      do_mut_r <= mut_hit;
      tries_r  <= '0;
    end
    if (cmd.exp_draw) k_r <= kprod[36:32];
    if (cmd.coin_step) begin
      val_r   <= stepped;
      tries_r <= tries_r + 1'b1;
    end
    if (cmd.next_gene) gcnt_r <= gcnt_r + 1'b1;
  end

  // Status to controller
  assign sts.op          = op_r;
  assign sts.bad_index   = bad_c;
  assign sts.picks_equal = (a_r == b_r);
  assign sts.genes_done  = (gcnt_r >= genes_eff);
  assign sts.mut_hit     = mut_hit;
  assign sts.do_mutate   = do_mut_r;
  assign sts.range_empty = (gene_max_r <= gene_min_r);
  assign sts.in_range    = inside_c;
  assign sts.tries_done  = (tries_r >= TryW'(TryLimit));

  // Output formatting: result fields are zero on error
  logic is_range, is_equal;
  assign is_range = bad_c;
  assign is_equal = !bad_c && (op_r == OP_TOURN) && (a_r == b_r);
  always_comb begin
    out_status       = ST_OK;
    out_loser_index  = '0;
    out_winner_index = '0;
    out_read_value   = '0;
    if (is_range)      out_status = ST_RANGE;
    else if (is_equal) out_status = ST_EQUAL;
    else if (op_r == OP_TOURN) begin
      out_loser_index  = lose_r;
      out_winner_index = win_r;
    end else if (op_r == OP_RD_GENE) begin
      out_read_value   = rdv_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.coin_step |=> (tries_r != '0))
    else $error("mutation attempt not counted");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gene_rd |-> (win_r != lose_r))
    else $error("tournament with equal contestants");
  assert property (@(posedge clk) disable iff (!rst_n)
    draw |=> (lfsr_r != 32'd0))
    else $error("LFSR reached zero");
endmodule
